// ===== design/rpf_pkg.sv =====
// ----------------------------------------------------------------------------
// rpf_pkg
// Shared types and constants for the packet framer: the preamble bytes,
// the operation codes and the burst of frame bytes that one item produces.
// ----------------------------------------------------------------------------
package rpf_pkg;

  localparam logic [7:0] SYNC_A    = 8'hFF;
  localparam logic [7:0] SYNC_B    = 8'h00;
  localparam logic [7:0] SYNC_LEAD = 8'hA5;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  localparam int BURST_MAX = 11;
  localparam int CNT_W     = $clog2(BURST_MAX + 1);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [CNT_W-1:0]             count;
    beat_t [BURST_MAX-1:0]        beats;
  } burst_t;

  typedef struct packed {
    logic       frame_open;
    logic [7:0] bytes_remaining;
  } status_t;

endpackage

// ===== design/rs485_packet_framer_unit.sv =====
// ----------------------------------------------------------------------------
// rs485_packet_framer_unit
// Serial frame builder: preamble, five header bytes, payload and a 16-bit
// sum, one frame byte per output transfer.
// ----------------------------------------------------------------------------
// A payload item is taken every cycle while the output takes every byte, and
// its byte appears on the output the cycle after it is accepted. A start item
// produces 9 bytes (11 when the length is zero) and the last payload item 3,
// so the input waits for those bursts to drain: an item is accepted once the
// output shift register holds no byte, or holds one that leaves in the same
// cycle. Payload items with no open frame are consumed and give no output.
module rs485_packet_framer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // protocol_id, dest_addr, src_addr, command_code, payload_length, payload_byte
  input  logic [47:0] s_tdata,
  // op
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_byte
  output logic [7:0]  m_tdata,
  output logic        m_tlast
);

  rpf_pkg::burst_t          burst;
  rpf_pkg::status_t         status;
  logic                     s_take;
  logic                     room;
  logic [rpf_pkg::CNT_W-1:0] level;

  assign s_tready = room;
  assign s_take   = s_tvalid && s_tready;

  rpf_frame_builder u_builder (
    .clk            (clk),
    .rst            (rst),
    .accept         (s_take),
    .op             (s_tuser[0]),
    .protocol_id    (s_tdata[7:0]),
    .dest_addr      (s_tdata[15:8]),
    .src_addr       (s_tdata[23:16]),
    .command_code   (s_tdata[31:24]),
    .payload_length (s_tdata[39:32]),
    .payload_byte   (s_tdata[47:40]),
    .burst          (burst),
    .status         (status)
  );

  rpf_byte_emitter u_emitter (
    .clk      (clk),
    .rst      (rst),
    .load     (s_take && (burst.count != '0)),
    .burst    (burst),
    .room     (room),
    .level    (level),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTHESIS
  // a start item always opens its burst with the first sync byte
  a_start_sync: assert property (@(posedge clk) disable iff (rst)
    s_take && (s_tuser[0] == rpf_pkg::OP_START)
    |=> m_tvalid && (m_tdata == rpf_pkg::SYNC_A) && (level != '0))
    else $error("start item did not begin with sync byte");

  // a payload item in an open frame yields a byte
  a_data_emits: assert property (@(posedge clk) disable iff (rst)
    s_take && (s_tuser[0] == rpf_pkg::OP_DATA) && status.frame_open |=> m_tvalid)
    else $error("payload item in open frame produced no byte");

  // the frame is closed whenever its final byte is on the output
  a_last_closed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !status.frame_open)
    else $error("frame still open on last byte");

  // an open frame always expects at least one more payload byte
  a_open_remaining: assert property (@(posedge clk) disable iff (rst)
    status.frame_open |-> (status.bytes_remaining != 8'd0))
    else $error("open frame with no payload bytes remaining");
`endif

endmodule

// ===== design/rpf_frame_builder.sv =====
// ----------------------------------------------------------------------------
// rpf_frame_builder
// Holds the frame state (running sum, bytes remaining, open flag) and turns
// one accepted item into the burst of frame bytes that it causes.
// ----------------------------------------------------------------------------
module rpf_frame_builder (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                op,
  input  logic [7:0]          protocol_id,
  input  logic [7:0]          dest_addr,
  input  logic [7:0]          src_addr,
  input  logic [7:0]          command_code,
  input  logic [7:0]          payload_length,
  input  logic [7:0]          payload_byte,
  output rpf_pkg::burst_t     burst,
  output rpf_pkg::status_t    status
);

  logic [15:0] running_sum;
  logic [15:0] running_sum_next;
  logic [7:0]  bytes_remaining;
  logic [7:0]  bytes_remaining_next;
  logic        frame_open;
  logic        frame_open_next;

  logic [15:0] hdr_sum;
  logic [15:0] data_sum;
  logic [7:0]  rem_dec;

  assign hdr_sum = 16'({8'h00, rpf_pkg::SYNC_LEAD}) + 16'({8'h00, protocol_id})
                 + 16'({8'h00, dest_addr}) + 16'({8'h00, src_addr})
                 + 16'({8'h00, command_code}) + 16'({8'h00, payload_length});
  assign data_sum = running_sum + 16'({8'h00, payload_byte});
  assign rem_dec  = bytes_remaining - 8'd1;

  always_comb begin
    burst                = '0;
    running_sum_next     = running_sum;
    bytes_remaining_next = bytes_remaining;
    frame_open_next      = frame_open;
    if (op == rpf_pkg::OP_START) begin
      burst.beats[0] = '{data: rpf_pkg::SYNC_A,    last: 1'b0};
      burst.beats[1] = '{data: rpf_pkg::SYNC_B,    last: 1'b0};
      burst.beats[2] = '{data: rpf_pkg::SYNC_A,    last: 1'b0};
      burst.beats[3] = '{data: rpf_pkg::SYNC_LEAD, last: 1'b0};
      burst.beats[4] = '{data: protocol_id,        last: 1'b0};
      burst.beats[5] = '{data: dest_addr,          last: 1'b0};
      burst.beats[6] = '{data: src_addr,           last: 1'b0};
      burst.beats[7] = '{data: command_code,       last: 1'b0};
      burst.beats[8] = '{data: payload_length,     last: 1'b0};
      if (payload_length == 8'd0) begin
        burst.beats[9]       = '{data: hdr_sum[15:8], last: 1'b0};
        burst.beats[10]      = '{data: hdr_sum[7:0],  last: 1'b1};
        burst.count          = rpf_pkg::CNT_W'(11);
        running_sum_next     = 16'd0;
        bytes_remaining_next = 8'd0;
        frame_open_next      = 1'b0;
      end else begin
        burst.count          = rpf_pkg::CNT_W'(9);
        running_sum_next     = hdr_sum;
        bytes_remaining_next = payload_length;
        frame_open_next      = 1'b1;
      end
    end else if (frame_open) begin
      burst.beats[0] = '{data: payload_byte, last: 1'b0};
      if (rem_dec == 8'd0) begin
        burst.beats[1]       = '{data: data_sum[15:8], last: 1'b0};
        burst.beats[2]       = '{data: data_sum[7:0],  last: 1'b1};
        burst.count          = rpf_pkg::CNT_W'(3);
        running_sum_next     = 16'd0;
        bytes_remaining_next = 8'd0;
        frame_open_next      = 1'b0;
      end else begin
        burst.count          = rpf_pkg::CNT_W'(1);
        running_sum_next     = data_sum;
        bytes_remaining_next = rem_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum     <= 16'd0;
      bytes_remaining <= 8'd0;
      frame_open      <= 1'b0;
    end else if (accept) begin
      running_sum     <= running_sum_next;
      bytes_remaining <= bytes_remaining_next;
      frame_open      <= frame_open_next;
    end
  end

  assign status.frame_open      = frame_open;
  assign status.bytes_remaining = bytes_remaining;

endmodule

// ===== design/rpf_byte_emitter.sv =====
// ----------------------------------------------------------------------------
// rpf_byte_emitter
// Result register: a shift line of frame bytes, loaded with a whole burst
// and drained one byte per output transfer.
// ----------------------------------------------------------------------------
module rpf_byte_emitter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  rpf_pkg::burst_t              burst,
  output logic                         room,
  output logic [rpf_pkg::CNT_W-1:0]    level,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [7:0]                   m_tdata,
  output logic                         m_tlast
);

  rpf_pkg::beat_t [rpf_pkg::BURST_MAX-1:0] beats;
  logic [rpf_pkg::CNT_W-1:0]               count;
  logic                                    take;

  assign take     = m_tvalid && m_tready;
  assign m_tvalid = (count != '0);
  assign m_tdata  = beats[0].data;
  assign m_tlast  = beats[0].last;
  assign room     = (count == '0) || ((count == rpf_pkg::CNT_W'(1)) && m_tready);
  assign level    = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= burst.count;
    end else if (take) begin
      count <= count - rpf_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beats <= burst.beats;
    end else if (take) begin
      for (int i = 0; i < rpf_pkg::BURST_MAX - 1; i++) begin
        beats[i] <= beats[i+1];
      end
      beats[rpf_pkg::BURST_MAX-1] <= '0;
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream testbench for the packet framer. Start and payload items go in with
// random header fields, lengths and contents, and the frame bytes that come
// out are matched in order against bytes built by a local frame tracker:
// preamble, header, payload and a wrapping 16-bit sum. Both sides idle at
// random; the output is held off at length once so the input backs up.
// ----------------------------------------------------------------------------
module tb;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;
  localparam int ITEM_TARGET = 480;

  class frame_tracker;
    rpf_pkg::beat_t bytes_due[$];
    logic [15:0]    frame_sum;
    logic [7:0]     left;
    logic           in_frame;
    int             errors;

    function void push_byte(logic [7:0] b, logic last);
      rpf_pkg::beat_t x;
      x.data = b;
      x.last = last;
      bytes_due.push_back(x);
    endfunction

    function void close_frame();
      push_byte(frame_sum[15:8], 1'b0);
      push_byte(frame_sum[7:0], 1'b1);
      frame_sum = '0;
      left = '0;
      in_frame = 1'b0;
    endfunction

    function void take_item(logic op, logic [47:0] word);
      if (op == rpf_pkg::OP_START) begin
        push_byte(rpf_pkg::SYNC_A, 1'b0);
        push_byte(rpf_pkg::SYNC_B, 1'b0);
        push_byte(rpf_pkg::SYNC_A, 1'b0);
        push_byte(rpf_pkg::SYNC_LEAD, 1'b0);
        frame_sum = {8'h00, rpf_pkg::SYNC_LEAD};
        for (int i = 0; i < 5; i++) begin
          push_byte(word[8*i +: 8], 1'b0);
          frame_sum = frame_sum + {8'h00, word[8*i +: 8]};
        end
        left = word[39:32];
        in_frame = 1'b1;
        if (left == 8'd0) close_frame();
      end else if (in_frame) begin
        push_byte(word[47:40], 1'b0);
        frame_sum = frame_sum + {8'h00, word[47:40]};
        left = left - 8'd1;
        if (left == 8'd0) close_frame();
      end
    endfunction

    task report(string msg);
      if (errors < 50) $display("tb: mismatch at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_byte(logic [7:0] b, logic last);
      rpf_pkg::beat_t want;
      if (bytes_due.size() == 0) begin
        report($sformatf("unexpected byte %02h last %b", b, last));
      end else begin
        want = bytes_due.pop_front();
        if (b !== want.data)
          report($sformatf("out_byte %02h, expected %02h", b, want.data));
        if (last !== want.last)
          report($sformatf("frame_end %b, expected %b", last, want.last));
      end
    endtask

    function int pending();
      return bytes_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // protocol_id, dest_addr, src_addr, command_code, payload_length, payload_byte
  logic [47:0] s_tdata = '0;
  // op
  logic [0:0]  s_tuser = rpf_pkg::OP_START;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // out_byte
  logic [7:0]  m_tdata;
  logic        m_tlast;

  frame_tracker tracker = new;
  bit calm;
  bit hold_out;
  int quiet_cycles;
  int item_count;

  rs485_packet_framer_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) tracker.take_item(s_tuser[0], s_tdata);
      if (m_tvalid && m_tready) tracker.check_byte(m_tdata, m_tlast);
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // output side
  initial begin
    int r;
    forever begin
      @(posedge clk);
      r = $urandom_range(0, 99);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_out) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end else if (calm) begin
        m_tready <= 1'b1;
      end else if (r < 3) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(8, 40)) @(posedge clk);
      end else begin
        m_tready <= (r < 75);
      end
    end
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task send_item(logic op, logic [47:0] word);
    int g;
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= word;
    do @(posedge clk); while (s_tready !== 1'b1);
    item_count++;
    g = calm ? 0 : pick_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      s_tdata <= 48'({$urandom(), $urandom()});
      repeat (g) @(posedge clk);
    end
  endtask

  task send_start(logic [7:0] proto, logic [7:0] dest, logic [7:0] src,
                  logic [7:0] cmd, logic [7:0] len);
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    send_item(rpf_pkg::OP_START, {junk, len, cmd, src, dest, proto});
  endtask

  task send_data(logic [7:0] b);
    logic [39:0] junk;
    junk = 40'({$urandom(), $urandom()});
    send_item(rpf_pkg::OP_DATA, {b, junk});
  endtask

  task wait_drained();
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task random_frame();
    int r;
    int len;
    int sent;
    bit broken;
    r = $urandom_range(0, 99);
    if (r < 10) len = 0;
    else if (r < 75) len = $urandom_range(1, 8);
    else if (r < 92) len = $urandom_range(9, 40);
    else if (r < 98) len = $urandom_range(41, 120);
    else len = 255;
    // keep the item total near the target
    if (item_count + len > ITEM_TARGET + 20) len = $urandom_range(1, 8);
    broken = (len > 0) && ($urandom_range(0, 99) < 12);
    sent = broken ? $urandom_range(0, len - 1) : len;
    send_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'(len));
    for (int i = 0; i < sent; i++) begin
      send_data(8'($urandom_range(0, 255)));
    end
    // stray payload with no open frame
    if (!broken && $urandom_range(0, 99) < 10)
      repeat ($urandom_range(1, 3)) send_data(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int phase;
    calm = 1'b0;
    hold_out = 1'b0;
    quiet_cycles = 0;
    item_count = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_data(8'h5A);
    send_start(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_start(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h02);
    send_data(8'hFF);
    send_data(8'h00);
    send_start(8'h12, 8'h34, 8'h56, 8'h78, 8'h03);
    send_data(8'hAA);
    send_start(8'h01, 8'h02, 8'h03, 8'h04, 8'h01);
    send_data(8'h80);
    send_data(8'h33);
    send_start(8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'h00);
    send_start(8'h80, 8'h01, 8'h7F, 8'hFE, 8'h01);
    send_data(8'h01);
    wait_drained();

    // longest frame, all ones, so the sum wraps; output held off midway
    calm = 1'b1;
    send_start(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    for (int i = 0; i < 255; i++) begin
      if (i == 20) hold_out = 1'b1;
      send_data(8'hFF);
    end
    wait_drained();
    calm = 1'b0;

    phase = 0;
    while (item_count < ITEM_TARGET) begin
      if (item_count >= (phase + 1) * 120) begin
        phase++;
        calm = ($urandom_range(0, 2) == 0);
        if (phase == 2) wait_drained();
      end
      random_frame();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
